### rtl/escape_sequence_decoder_unit_macros.svh
// Assertion macros shared by the escape sequence decoder checkers.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ESCAPE_SEQUENCE_DECODER_UNIT_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ESDU_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("escape decoder check failed");

// Next-cycle implication, disabled while reset is held.
`define ESDU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("escape decoder check failed");

`endif

### rtl/esdu_pkg.sv
// Constants for the escape sequence decoder: byte width, escape characters, limits.
// No dependencies; imported by the decoder top level and its checker.
package esdu_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned ACC_W  = 10;

    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [CHAR_W-1:0] CH_T         = 8'h74;
    localparam logic [CHAR_W-1:0] CH_N         = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_R         = 8'h72;
    localparam logic [CHAR_W-1:0] CH_A         = 8'h61;
    localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE      = 8'h39;

    localparam logic [CHAR_W-1:0] CODE_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_CR  = 8'h0D;

    localparam logic [ACC_W-1:0] CODE_MAX = 10'd255;

endpackage

### rtl/escape_sequence_decoder_unit.sv
// Backslash escape decoder: one input byte per item, zero or one result per item.
// Depends on esdu_pkg.
// Path: input register, then result register. Throughput: one item per cycle unless
// m_tready stalls the result stage; decode state is updated in the single result stage.
// s_tready follows m_tready combinationally when both stages are full.
// Reset (aresetn low, synchronous): pipeline emptied, plain byte mode, no error.
module escape_sequence_decoder_unit
    import esdu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // [7:0] in_byte
    input  logic              s_tlast,   // last_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,   // [7:0] out_char
    output logic [1:0]        m_tuser,   // [0] byte_valid, [1] decode_error
    output logic              m_tlast    // end_of_string
);

    typedef enum logic [2:0] {
        MODE_PLAIN,
        MODE_ESCAPE,
        MODE_DIG1,
        MODE_DIG2,
        MODE_DIG3,
        MODE_DRAIN
    } mode_t;

    logic              in_vld_reg;
    logic [CHAR_W-1:0] in_byte_reg;
    logic              in_last_reg;

    mode_t             mode_reg, mode_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              err_reg, err_next;

    logic              out_vld_reg, out_vld_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_bv_reg, out_bv_next;
    logic              out_err_reg, out_err_next;
    logic              out_eos_reg, out_eos_next;

    logic              out_free;
    logic              step;
    logic              have;
    logic [CHAR_W-1:0] ch;
    logic              is_digit;
    logic [ACC_W-1:0]  acc_sum;
    mode_t             mode_dec;
    logic [ACC_W-1:0]  acc_dec;
    logic              err_dec;

    assign out_free = !out_vld_reg || m_tready;
    assign step     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;

    assign is_digit = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_NINE);
    assign acc_sum  = (acc_reg << 3) + (acc_reg << 1)
                    + {{(ACC_W-CHAR_W){1'b0}}, in_byte_reg - CH_ZERO};

    always_comb begin
        have     = 1'b0;
        ch       = '0;
        mode_dec = mode_reg;
        acc_dec  = acc_reg;
        err_dec  = err_reg;
        unique case (mode_reg)
            MODE_PLAIN: begin
                if (in_byte_reg == CH_BACKSLASH) begin
                    mode_dec = MODE_ESCAPE;
                end else begin
                    have = 1'b1;
                    ch   = in_byte_reg;
                end
            end
            MODE_ESCAPE: begin
                mode_dec = MODE_PLAIN;
                unique case (in_byte_reg)
                    CH_BACKSLASH: begin have = 1'b1; ch = CH_BACKSLASH; end
                    CH_QUOTE:     begin have = 1'b1; ch = CH_QUOTE;     end
                    CH_T:         begin have = 1'b1; ch = CODE_TAB;     end
                    CH_N:         begin have = 1'b1; ch = CODE_LF;      end
                    CH_R:         begin have = 1'b1; ch = CODE_CR;      end
                    CH_A: begin
                        mode_dec = MODE_DIG1;
                        acc_dec  = '0;
                    end
                    default: begin
                        err_dec  = 1'b1;
                        mode_dec = MODE_DRAIN;
                        acc_dec  = '0;
                    end
                endcase
            end
            MODE_DIG1, MODE_DIG2, MODE_DIG3: begin
                if (!is_digit) begin
                    err_dec  = 1'b1;
                    mode_dec = MODE_DRAIN;
                    acc_dec  = '0;
                end else if (mode_reg == MODE_DIG3) begin
                    if (acc_sum > CODE_MAX) begin
                        err_dec  = 1'b1;
                        mode_dec = MODE_DRAIN;
                        acc_dec  = '0;
                    end else begin
                        have     = 1'b1;
                        ch       = acc_sum[CHAR_W-1:0];
                        mode_dec = MODE_PLAIN;
                        acc_dec  = '0;
                    end
                end else begin
                    acc_dec  = acc_sum;
                    mode_dec = (mode_reg == MODE_DIG1) ? MODE_DIG2 : MODE_DIG3;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mode_next     = mode_reg;
        acc_next      = acc_reg;
        err_next      = err_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_char_next = out_char_reg;
        out_bv_next   = out_bv_reg;
        out_err_next  = out_err_reg;
        out_eos_next  = out_eos_reg;
        if (step) begin
            out_char_next = have ? ch : '0;
            out_bv_next   = have;
            if (in_last_reg) begin
                // a string that ends inside a numeric escape is an error
                out_err_next = err_dec || mode_dec == MODE_DIG1
                             || mode_dec == MODE_DIG2 || mode_dec == MODE_DIG3;
                out_eos_next = 1'b1;
                out_vld_next = 1'b1;
                mode_next    = MODE_PLAIN;
                acc_next     = '0;
                err_next     = 1'b0;
            end else begin
                out_err_next = 1'b0;
                out_eos_next = 1'b0;
                out_vld_next = have;
                mode_next    = mode_dec;
                acc_next     = acc_dec;
                err_next     = err_dec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            mode_reg    <= MODE_PLAIN;
            acc_reg     <= '0;
            err_reg     <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            out_vld_reg <= out_vld_next;
            mode_reg    <= mode_next;
            acc_reg     <= acc_next;
            err_reg     <= err_next;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        out_char_reg <= out_char_next;
        out_bv_reg   <= out_bv_next;
        out_err_reg  <= out_err_next;
        out_eos_reg  <= out_eos_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = {out_err_reg, out_bv_reg};
    assign m_tlast  = out_eos_reg;

endmodule

### rtl/esdu_checker.sv
// Port-level checker for escape_sequence_decoder_unit, attached by bind.
// Depends on esdu_pkg and escape_sequence_decoder_unit_macros.svh.
`include "escape_sequence_decoder_unit_macros.svh"

module esdu_checker
    import esdu_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [CHAR_W-1:0] m_tdata,   // [7:0] out_char
    input logic [1:0]        m_tuser,   // [0] byte_valid, [1] decode_error
    input logic              m_tlast    // end_of_string
);

    // error status only ever appears on the end item
    `ESDU_ASSERT_IMPLY(a_err_on_end, aclk, aresetn, m_tvalid && m_tuser[1], m_tlast)
    // an item with no decoded byte must be the end item
    `ESDU_ASSERT_IMPLY(a_empty_is_end, aclk, aresetn, m_tvalid && !m_tuser[0], m_tlast)
    // an errored string never delivers a byte on its end item
    `ESDU_ASSERT_IMPLY(a_err_no_byte, aclk, aresetn, m_tvalid && m_tuser[1], !m_tuser[0] && m_tdata == '0)
    `ESDU_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    // input side is never held off while the result stage can move
    `ESDU_ASSERT_IMPLY(a_ready_when_free, aclk, aresetn, !m_tvalid || m_tready, s_tready)

endmodule

bind escape_sequence_decoder_unit esdu_checker u_esdu_checker (.*);
